// ===== sv/nwtp_pkg.sv =====
// Shared types and constants for the nearest waypoint track projection block.
// No dependencies.
package nwtp_pkg;
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic [1:0] REG_BODY_WIDTH = 2'd0;
	localparam logic [1:0] REG_MARGIN     = 2'd1;

	localparam logic [22:0] HEAD_WEIGHT = 23'd4139612;
	localparam logic [48:0] VALID_LIMIT = 49'd4194304;
	localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] S24_MIN = -24'sh800000;

	// one stored waypoint
	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic [15:0] hdg;
		logic [15:0] right;
		logic [15:0] left;
	} waypoint_t;

	localparam int WP_W = $bits(waypoint_t);

	// Q15 quarter sine entry; nwtp_sine builds its depth + 1 entries as a constant table
	function automatic logic [15:0] sine_entry(input int k, input int depth);
		logic [63:0] x, x2, t;
		longint sum;
		int n;
		x = (64'd1686629713 * 64'(k) + 64'(depth / 2)) / 64'(depth);
		x2 = (x * x) >> 30;
		t = x;
		sum = longint'(x);
		for (n = 1; n <= 6; n++) begin
			t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if ((n & 1) != 0) sum = sum - longint'(t);
			else sum = sum + longint'(t);
		end
		if (sum < 0) sum = 0;
		return 16'((64'(sum) + 64'd16384) >> 15);
	endfunction
endpackage

// ===== sv/nwtp_sine.sv =====
// Registered quarter-wave sine and cosine lookup for one binary angle.
// Depends on nwtp_pkg.
module nwtp_sine #(
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic clk,
	input  logic [15:0] angle,
	output logic signed [16:0] sin_q,
	output logic signed [16:0] cos_q
);
	localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);

	logic [15:0] table_c [0:SINE_TABLE_DEPTH];

	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
		assign table_c[k] = nwtp_pkg::sine_entry(k, SINE_TABLE_DEPTH);
	end

	// sign flag on top, quadrant-mirrored table index below
	function automatic logic [IW:0] table_addr(input logic [15:0] a);
		logic [47:0] p;
		logic [IW-1:0] idx;
		p = (48'(a[13:0]) * 48'(SINE_TABLE_DEPTH) + 48'd8192) >> 14;
		idx = (p > 48'(SINE_TABLE_DEPTH)) ? IW'(SINE_TABLE_DEPTH) : p[IW-1:0];
		if (a[14]) idx = IW'(SINE_TABLE_DEPTH) - idx;
		return {a[15], idx};
	endfunction

	logic [IW:0] sin_a, cos_a;
	logic [15:0] sin_m, cos_m;

	assign sin_a = table_addr(angle);
	assign cos_a = table_addr(angle + 16'd16384);
	assign sin_m = table_c[sin_a[IW-1:0]];
	assign cos_m = table_c[cos_a[IW-1:0]];

	always_ff @(posedge clk) begin
		sin_q <= sin_a[IW] ? -17'(sin_m) : 17'(sin_m);
		cos_q <= cos_a[IW] ? -17'(cos_m) : 17'(cos_m);
	end
endmodule

// ===== sv/nearest_waypoint_track_projection_top.sv =====
// Nearest waypoint track projection: waypoint memory, scan and projection.
// Depends on nwtp_pkg and nwtp_sine.
//
// Usage: drive command and the pose or waypoint fields with start high while
// busy is low; the word is taken at that edge. Clear and append keep busy
// low and give no result. A query reads one waypoint per cycle from the
// single-port waypoint memory, scores it in a three-stage pipe, drains
// that pipe, then reads back the winner and runs a projection tail. A
// query holds busy high until its result shows, so no new word is taken
// while it runs. A query on an empty table registers its result at the
// accepting edge and keeps busy low. The result shows for one cycle with
// done high; the receiver cannot stall it.
// Configuration writes (cfg_valid/cfg_ready, index 0 body width, index 1
// boundary margin) are always taken. Reset clears the count, state and pipe
// valid flags and loads the configuration defaults; the memory itself
// needs no clearing pass since only entries below the count are read.
module nearest_waypoint_track_projection_top #(
	parameter int TRACK_DEPTH = 1024,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] command,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic [15:0] heading,
	input  logic [15:0] right_width,
	input  logic [15:0] left_width,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data,
	output logic done,
	output logic valid_res,
	output logic [9:0] nearest_index,
	output logic signed [23:0] lateral_offset,
	output logic signed [23:0] track_margin,
	output logic signed [15:0] hdg_error
);
	localparam int AW = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
	localparam int CW = $clog2(TRACK_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_DRAIN, ST_FETCH, ST_WAIT, ST_TRIG, ST_MUL, ST_SUM,
		ST_OUT
	} state_t;

	nwtp_pkg::waypoint_t mem [0:TRACK_DEPTH-1];
	nwtp_pkg::waypoint_t rd_s1;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] addr_q;
	logic [15:0] body_q, margin_q;
	logic signed [23:0] vx_q, vy_q;
	logic [15:0] vh_q;
	logic mem_we;
	logic [AW-1:0] mem_addr;
	logic vld_s1;
	logic [AW-1:0] idx_s1;
	logic vld_s2;
	logic [AW-1:0] idx_s2;
	logic [47:0] sqx_s2, sqy_s2;
	logic [31:0] ae2_s2;
	logic vld_s3;
	logic [AW-1:0] idx_s3;
	logic [48:0] dist_s3, hscore_s3;
	logic first_q;
	logic [48:0] min_score_q, best_dist_q;
	logic [AW-1:0] best_i_q;
	logic signed [24:0] dx_q, dy_q;
	logic signed [16:0] sin_q, cos_q;
	logic signed [42:0] ps_q, pc_q;
	logic signed [43:0] lat_q;
	logic [15:0] herr_q;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_q <= 16'd246;
			margin_q <= 16'd102;
		end else if (cfg_valid) begin
			if (cfg_index == nwtp_pkg::REG_BODY_WIDTH) body_q <= cfg_data;
			else if (cfg_index == nwtp_pkg::REG_MARGIN) margin_q <= cfg_data;
		end
	end

	assign mem_we = start && !busy && command == nwtp_pkg::CMD_APPEND
		&& count_q < CW'(TRACK_DEPTH);
	always_comb begin
		if (mem_we) mem_addr = count_q[AW-1:0];
		else if (state_q == ST_SCAN) mem_addr = addr_q[AW-1:0];
		else mem_addr = best_i_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= '{x: pos_x, y: pos_y, hdg: heading,
			right: right_width, left: left_width};
		rd_s1 <= mem[mem_addr];
	end

	// scoring stage: differences and their magnitudes
	logic signed [24:0] ex, ey;
	logic [24:0] ax, ay;
	logic [15:0] e16;
	logic [15:0] ae;
	logic [54:0] hterm;
	assign ex = 25'(vx_q) - 25'(rd_s1.x);
	assign ey = 25'(vy_q) - 25'(rd_s1.y);
	assign ax = ex[24] ? 25'(-ex) : 25'(ex);
	assign ay = ey[24] ? 25'(-ey) : 25'(ey);
	assign e16 = vh_q - rd_s1.hdg;
	assign ae = e16[15] ? 16'(-e16) : e16;
	assign hterm = (55'(ae2_s2) * 55'(nwtp_pkg::HEAD_WEIGHT) + 55'h80000000) >> 32;

	nwtp_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine (
		.clk(clk), .angle(rd_s1.hdg), .sin_q(sin_q), .cos_q(cos_q));

	logic signed [43:0] lat_sh;
	logic signed [25:0] fp;
	logic signed [45:0] m1, m2, mm;
	assign lat_sh = lat_q >>> 15;
	assign fp = 26'((17'(body_q) + 17'd1) >> 1) + 26'(margin_q);
	assign m1 = 46'(rd_s1.left) - 46'(fp) - 46'(lat_sh);
	assign m2 = 46'(rd_s1.right) - 46'(fp) + 46'(lat_sh);
	assign mm = (m1 < m2) ? m1 : m2;

	function automatic logic signed [23:0] sat(input logic signed [45:0] v);
		if (v > 46'(nwtp_pkg::S24_MAX)) return nwtp_pkg::S24_MAX;
		if (v < 46'(nwtp_pkg::S24_MIN)) return nwtp_pkg::S24_MIN;
		return v[23:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			addr_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			first_q <= 1'b1;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			vld_s1 <= (state_q == ST_SCAN);
			idx_s1 <= addr_q[AW-1:0];
			vld_s2 <= vld_s1;
			idx_s2 <= idx_s1;
			sqx_s2 <= 48'(ax) * 48'(ax);
			sqy_s2 <= 48'(ay) * 48'(ay);
			ae2_s2 <= 32'(ae) * 32'(ae);
			vld_s3 <= vld_s2;
			idx_s3 <= idx_s2;
			dist_s3 <= 49'(sqx_s2) + 49'(sqy_s2);
			hscore_s3 <= 49'(hterm);
			if (vld_s3) begin
				if (first_q || (dist_s3 + hscore_s3) < min_score_q) begin
					min_score_q <= dist_s3 + hscore_s3;
					best_dist_q <= dist_s3;
					best_i_q <= idx_s3;
				end
				first_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						vx_q <= pos_x;
						vy_q <= pos_y;
						vh_q <= heading;
						addr_q <= '0;
						first_q <= 1'b1;
						if (command == nwtp_pkg::CMD_CLEAR) count_q <= '0;
						else if (mem_we) count_q <= count_q + 1'b1;
						else if (command == nwtp_pkg::CMD_QUERY) begin
							if (count_q == '0) begin
								done <= 1'b1;
								valid_res <= 1'b0;
								nearest_index <= '0;
								lateral_offset <= '0;
								hdg_error <= '0;
								track_margin <= nwtp_pkg::S24_MIN;
							end else state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// one memory read per cycle
					addr_q <= addr_q + 1'b1;
					if (addr_q == count_q - 1'b1) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					// wait for the scoring pipe to empty
					if (!vld_s1 && !vld_s2 && !vld_s3) state_q <= ST_FETCH;
				end
				ST_FETCH: state_q <= ST_WAIT;
				ST_WAIT: begin
					dx_q <= 25'(vx_q) - 25'(rd_s1.x);
					dy_q <= 25'(vy_q) - 25'(rd_s1.y);
					herr_q <= vh_q - rd_s1.hdg;
					state_q <= ST_TRIG;
				end
				ST_TRIG: state_q <= ST_MUL;
				ST_MUL: begin
					ps_q <= 43'(sin_q) * 43'(dx_q);
					pc_q <= 43'(cos_q) * 43'(dy_q);
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					lat_q <= 44'(pc_q) - 44'(ps_q) + 44'sd16384;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					done <= 1'b1;
					valid_res <= best_dist_q < nwtp_pkg::VALID_LIMIT;
					nearest_index <= 10'(best_i_q);
					lateral_offset <= sat(46'(lat_sh));
					track_margin <= sat(mm);
					hdg_error <= herr_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/nwtp_checker.sv =====
// Port-level checks for the nearest waypoint track projection block.
// Depends on nearest_waypoint_track_projection_top's ports.
module nwtp_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic valid_res,
	input logic signed [23:0] track_margin
);
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("busy without a word");
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(busy) |-> !busy) else $error("busy after result");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && !$past(busy) |-> !valid_res && track_margin == -24'sd8388608)
		else $error("empty query result wrong");
endmodule

bind nearest_waypoint_track_projection_top nwtp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.valid_res(valid_res), .track_margin(track_margin));

// ===== test/nearest_waypoint_track_projection_top_tb.sv =====
// Testbench for nearest_waypoint_track_projection_top: directed and random words,
// with a scoreboard class that predicts each query result. Depends on nwtp_pkg.
`timescale 1ns / 1ps

module nearest_waypoint_track_projection_top_tb;
	localparam int DEPTH = 1024;
	localparam int SINE_N = 256;
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam int ITEM_TARGET = 560;

	typedef struct {
		logic valid;
		logic [9:0] idx;
		logic signed [23:0] lat;
		logic signed [23:0] margin;
		logic signed [15:0] herr;
	} projection_t;

	class projection_scoreboard;
		logic signed [23:0] wx[DEPTH], wy[DEPTH];
		logic [15:0] wh[DEPTH], wr[DEPTH], wl[DEPTH];
		int count;
		int body_w, clearance;
		int errors;
		int sine_q15[SINE_N + 1];
		projection_t pending[$];

		function new();
			longint unsigned x, x2, t;
			longint sum;
			count = 0;
			body_w = 246;
			clearance = 102;
			errors = 0;
			for (int k = 0; k <= SINE_N; k++) begin
				x = (64'd1686629713 * k + SINE_N / 2) / SINE_N;
				x2 = (x * x) >> 30;
				t = x;
				sum = x;
				for (int n = 1; n <= 6; n++) begin
					t = ((t * x2) >> 30) / ((2 * n) * (2 * n + 1));
					if (n % 2 == 1) sum -= t;
					else sum += t;
				end
				if (sum < 0) sum = 0;
				sine_q15[k] = int'((sum + 16384) >> 15);
			end
		endfunction

		function int sin_lookup(logic [15:0] a);
			int idx, v;
			idx = ((int'(a[13:0]) * SINE_N) + 8192) >> 14;
			if (idx > SINE_N) idx = SINE_N;
			v = a[14] ? sine_q15[SINE_N - idx] : sine_q15[idx];
			return a[15] ? -v : v;
		endfunction

		function longint clip24(longint v);
			if (v > 8388607) return 8388607;
			if (v < -8388608) return -8388608;
			return v;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] data);
			if (idx == nwtp_pkg::REG_BODY_WIDTH) body_w = data;
			else if (idx == nwtp_pkg::REG_MARGIN) clearance = data;
		endfunction

		function void note_word(logic [1:0] cmd, logic signed [23:0] px, logic signed [23:0] py,
				logic [15:0] hd, logic [15:0] rw, logic [15:0] lw);
			projection_t r;
			longint ex, ey, sq_dist, score, low_score, best_dist, lat, fp, m1, m2;
			logic signed [15:0] e;
			longint ae;
			int best, s, c;
			case (cmd)
				nwtp_pkg::CMD_CLEAR: count = 0;
				nwtp_pkg::CMD_APPEND: begin
					if (count < DEPTH) begin
						wx[count] = px; wy[count] = py; wh[count] = hd;
						wr[count] = rw; wl[count] = lw;
						count++;
					end
				end
				nwtp_pkg::CMD_QUERY: begin
					if (count == 0) begin
						r.valid = 0; r.idx = 0; r.lat = 0; r.herr = 0;
						r.margin = nwtp_pkg::S24_MIN;
					end else begin
						best = 0; low_score = 0; best_dist = 0;
						for (int i = 0; i < count; i++) begin
							ex = longint'(px) - longint'(wx[i]);
							ey = longint'(py) - longint'(wy[i]);
							sq_dist = ex * ex + ey * ey;
							e = hd - wh[i];
							ae = e;
							score = sq_dist + ((ae * ae * 4139612 + 64'h80000000) >>> 32);
							if (i == 0 || score < low_score) begin
								low_score = score; best_dist = sq_dist; best = i;
							end
						end
						ex = longint'(px) - longint'(wx[best]);
						ey = longint'(py) - longint'(wy[best]);
						s = sin_lookup(wh[best]);
						c = sin_lookup(wh[best] + 16'd16384);
						lat = (-longint'(s) * ex + longint'(c) * ey + 16384) >>> 15;
						fp = ((body_w + 1) >> 1) + clearance;
						m1 = longint'(wl[best]) - fp - lat;
						m2 = longint'(wr[best]) - fp + lat;
						r.valid = best_dist < 4194304;
						r.idx = best[9:0];
						r.lat = clip24(lat);
						r.margin = clip24(m1 < m2 ? m1 : m2);
						r.herr = hd - wh[best];
					end
					pending.insert(pending.size(), r);
				end
				default: ;
			endcase
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_result(projection_t got);
			projection_t w;
			if (pending.size() == 0) begin
				report("unexpected result word", 1, 0);
				return;
			end
			w = pending.pop_front();
			if (got.valid !== w.valid) report("valid_res", got.valid, w.valid);
			if (got.idx !== w.idx) report("nearest_index", got.idx, w.idx);
			if (got.lat !== w.lat) report("lateral_offset", got.lat, w.lat);
			if (got.margin !== w.margin) report("track_margin", got.margin, w.margin);
			if (got.herr !== w.herr) report("hdg_error", got.herr, w.herr);
		endtask
	endclass

	logic clk, arst_n, start, busy, cfg_valid, cfg_ready, done, valid_res;
	logic [1:0] command, cfg_index;
	logic signed [23:0] pos_x, pos_y, lateral_offset, track_margin;
	logic [15:0] heading, right_width, left_width, cfg_data;
	logic [9:0] nearest_index;
	logic signed [15:0] hdg_error;

	projection_scoreboard sb;
	int stall_cycles;
	int items;
	bit no_gaps;

	nearest_waypoint_track_projection_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
		.right_width(right_width), .left_width(left_width),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .valid_res(valid_res),
		.nearest_index(nearest_index), .lateral_offset(lateral_offset),
		.track_margin(track_margin), .hdg_error(hdg_error)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// result words last one cycle and cannot be held off
	always @(posedge clk) begin
		projection_t r;
		if (arst_n && done) begin
			r.valid = valid_res; r.idx = nearest_index; r.lat = lateral_offset;
			r.margin = track_margin; r.herr = hdg_error;
			sb.check_result(r);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task send(logic [1:0] cmd, logic signed [23:0] px, logic signed [23:0] py,
			logic [15:0] hd, logic [15:0] rw, logic [15:0] lw);
		int gap;
		@(negedge clk);
		start = 1; command = cmd; pos_x = px; pos_y = py;
		heading = hd; right_width = rw; left_width = lw;
		do @(posedge clk); while (busy);
		sb.note_word(cmd, px, py, hd, rw, lw);
		if (cmd != CMD_NOP) items++;
		gap = no_gaps ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			@(negedge clk);
			start = 0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task send_random(logic [1:0] cmd);
		send(cmd, 24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom));
	endtask

	// drain to idle with no results pending, then pause with start low
	task settle();
		@(negedge clk);
		start = 0;
		while (sb.pending.size() != 0 || busy) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_valid = 1; cfg_index = idx; cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task random_phase();
		int n, j, step;
		logic signed [23:0] bx, by;
		logic [15:0] h;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		bx = ($urandom_range(0, 4) == 0) ? 24'($urandom)
			: 24'($urandom_range(0, 200000)) - 24'd100000;
		by = ($urandom_range(0, 4) == 0) ? 24'($urandom)
			: 24'($urandom_range(0, 200000)) - 24'd100000;
		h = 16'($urandom);
		step = $urandom_range(100, 1500);
		no_gaps = $urandom_range(0, 3) == 0;
		send_random(nwtp_pkg::CMD_CLEAR);
		for (int i = 0; i < n; i++) begin
			send(nwtp_pkg::CMD_APPEND, bx + 24'(i * step) + 24'($urandom_range(0, 200)),
				by + 24'(i * step / 2) - 24'($urandom_range(0, 200)),
				h + 16'($urandom_range(0, 3000)), 16'($urandom), 16'($urandom));
		end
		repeat ($urandom_range(3, 10)) begin
			case ($urandom_range(0, 9))
				0: send_random(nwtp_pkg::CMD_QUERY);
				1: send_random(CMD_NOP);
				2: send(nwtp_pkg::CMD_APPEND, bx - 24'($urandom_range(0, 3000)), by,
					16'($urandom), 16'($urandom), 16'($urandom));
				default: begin
					j = $urandom_range(0, sb.count - 1);
					send(nwtp_pkg::CMD_QUERY,
						sb.wx[j] + 24'($urandom_range(0, 6000)) - 24'd3000,
						sb.wy[j] + 24'($urandom_range(0, 6000)) - 24'd3000,
						($urandom_range(0, 3) == 0) ? 16'($urandom)
							: sb.wh[j] + 16'($urandom_range(0, 4000)) - 16'd2000,
						16'($urandom), 16'($urandom));
				end
			endcase
		end
		if ($urandom_range(0, 5) == 0) begin
			send(nwtp_pkg::CMD_CLEAR, '0, '0, '0, '0, '0);
			send_random(nwtp_pkg::CMD_QUERY);
		end
	endtask

	initial begin
		logic [15:0] settings[6][2];
		sb = new();
		settings = '{'{16'd246, 16'd102}, '{16'd0, 16'd0}, '{16'hFFFF, 16'hFFFF},
			'{16'd0, 16'hFFFF}, '{16'hFFFF, 16'd0}, '{16'd301, 16'd57}};
		arst_n = 0; start = 0; command = CMD_NOP; pos_x = '0; pos_y = '0; heading = '0;
		right_width = '0; left_width = '0; cfg_valid = 0;
		cfg_index = nwtp_pkg::REG_BODY_WIDTH;
		cfg_data = '0; items = 0; no_gaps = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty query, extremes, saturation, tie, no-op, wrap
		send(nwtp_pkg::CMD_QUERY, '0, '0, '0, '0, '0);
		send(nwtp_pkg::CMD_APPEND, nwtp_pkg::S24_MAX, nwtp_pkg::S24_MAX,
			16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(nwtp_pkg::CMD_APPEND, nwtp_pkg::S24_MIN, nwtp_pkg::S24_MIN,
			16'h0000, 16'h0000, 16'h0000);
		send(nwtp_pkg::CMD_APPEND, '0, '0, 16'h8000, 16'd100, 16'd200);
		send(CMD_NOP, nwtp_pkg::S24_MAX, nwtp_pkg::S24_MIN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(nwtp_pkg::CMD_QUERY, 24'sd300, -24'sd200, 16'h7FFF, '0, '0);
		send(nwtp_pkg::CMD_QUERY, nwtp_pkg::S24_MAX, nwtp_pkg::S24_MAX, 16'h0001, '0, '0);
		send(nwtp_pkg::CMD_QUERY, nwtp_pkg::S24_MIN, nwtp_pkg::S24_MAX, 16'h0000, '0, '0);
		send(nwtp_pkg::CMD_QUERY, nwtp_pkg::S24_MAX, nwtp_pkg::S24_MIN, 16'h4000, '0, '0);
		send(nwtp_pkg::CMD_APPEND, '0, '0, 16'h8000, 16'd5, 16'd7);
		send(nwtp_pkg::CMD_QUERY, 24'sd10, 24'sd10, 16'h8000, '0, '0);
		send(nwtp_pkg::CMD_QUERY, 24'sd2047, '0, 16'h8000, '0, '0);
		send(nwtp_pkg::CMD_QUERY, 24'sd2048, '0, 16'h8000, '0, '0);
		send(nwtp_pkg::CMD_CLEAR, nwtp_pkg::S24_MAX, nwtp_pkg::S24_MAX,
			16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(nwtp_pkg::CMD_QUERY, 24'sd5, 24'sd5, 16'd5, '0, '0);
		settle();
		write_reg(REG_SPARE_A, 16'hFFFF);
		write_reg(REG_SPARE_B, 16'h1234);

		for (int p = 0; items < ITEM_TARGET; p++) begin
			if (p % 6 == 0) begin
				settle();
				write_reg(nwtp_pkg::REG_BODY_WIDTH, settings[(p / 6) % 6][0]);
				write_reg(nwtp_pkg::REG_MARGIN, settings[(p / 6) % 6][1]);
			end
			random_phase();
		end

		settle();
		repeat (50) @(posedge clk);
		if (sb.errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule

// ===== files.f =====
sv/nwtp_pkg.sv
sv/nwtp_sine.sv
sv/nearest_waypoint_track_projection_top.sv
sv/nwtp_checker.sv
test/nearest_waypoint_track_projection_top_tb.sv
